FILE: rtl/jacobi_grid_relaxation_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Jacobi grid relaxation unit
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef JACOBI_GRID_RELAXATION_UNIT_ASSERT_SVH
`define JACOBI_GRID_RELAXATION_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define JGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, prop must hold in the next cycle.
`define JGR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/jgr_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi grid relaxation package
// Widths, codes, reset values and shared types of the relaxation unit.
// ----------------------------------------------------------------------------
package jgr_pkg;

  localparam int DEF_MAX_SIDE   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PREC_W     = 16;
  localparam int COUNT_W    = 16;

  localparam logic [KIND_W-1:0] KIND_WRITE = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_RUN   = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = CFG_IDX_W'(2);

  localparam logic [PREC_W-1:0]  PRECISION_RESET  = PREC_W'(66);
  localparam logic [COUNT_W-1:0] MAX_SWEEPS_RESET = COUNT_W'(65535);

  typedef enum logic [2:0] {
    T_IDLE,
    T_READ,
    T_LAUNCH,
    T_SWEEP,
    T_REPLY
  } top_state_t;

  typedef enum logic {
    SW_IDLE,
    SW_CELL
  } sweep_state_t;

  typedef struct packed {
    logic done;
    logic calm;
  } sweep_stat_t;

endpackage

FILE: rtl/jacobi_grid_relaxation_unit.sv
// ----------------------------------------------------------------------------
// Jacobi grid relaxation unit
// Square grid of unsigned fractions in two ping-pong banks, relaxed by four-point
// Laplace sweeps until every change is within precision or a sweep limit is hit.
// ----------------------------------------------------------------------------
// A write request stores the cell into both banks; a read request waits for
// the registered bank read. During a run request each interior cell needs
// five reads through the single read port of the source bank, the four
// neighbors one after another into one shared accumulator and then the
// center, and then one write to the other bank, and every sweep begins
// with a launch state. Every request returns exactly one result, held in an
// output register, and the unit takes no new request while one is in progress
// or while a result is stalled at the output. Cells that were never written
// read as unknown.
`include "jacobi_grid_relaxation_unit_assert.svh"

module jacobi_grid_relaxation_unit import jgr_pkg::*; #(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [KIND_W-1:0]             kind,
  input  logic [$clog2(MAX_SIDE)-1:0]   row,
  input  logic [$clog2(MAX_SIDE)-1:0]   column,
  input  logic [VALUE_BITS-1:0]         cell_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [VALUE_BITS-1:0]         read_value,
  output logic [COUNT_W-1:0]            sweeps_done,
  output logic                          converged
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  top_state_t state, state_next;

  logic [SIDE_W-1:0]  side_reg;
  logic [PREC_W-1:0]  precision_reg;
  logic [COUNT_W-1:0] max_sweeps_reg;

  logic               newest;
  logic [COUNT_W-1:0] sweep_count;
  logic               settled;
  logic [COUNT_W-1:0] run_count;
  logic               read_inside;

  logic               out_free, accept, item_write, item_read, item_inside;
  logic [ADDR_W-1:0]  item_addr;
  logic [SIDE_W-1:0]  side_used;
  logic [COUNT_W-1:0] limit;
  logic               last_sweep;

  logic               start;
  sweep_stat_t        sweep_stat;
  logic               eng_rd_en, eng_wr_en;
  logic [ADDR_W-1:0]  eng_rd_addr, eng_wr_addr;
  logic [VALUE_BITS-1:0] eng_wr_data;

  logic [1:0]            bank_we;
  logic                  bank_re;
  logic [ADDR_W-1:0]     bank_waddr, bank_raddr;
  logic [VALUE_BITS-1:0] bank_wdata, rdata_a, rdata_b, bank_rdata;

  logic                  result_load;
  logic [VALUE_BITS-1:0] load_read_value;

  assign out_free    = !result_valid || !result_stall;
  assign accept      = item_valid && !item_stall;
  assign item_inside = {1'b0, row} < (IDX_W + 1)'(MAX_SIDE) &&
                       {1'b0, column} < (IDX_W + 1)'(MAX_SIDE);
  assign item_addr   = {row, column};
  assign item_write  = accept && (kind == KIND_WRITE) && item_inside;
  assign item_read   = accept && (kind == KIND_READ);

  assign side_used  = (side_reg < SIDE_W'(3)) ? SIDE_W'(3) :
                      (side_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_reg;
  assign limit      = (max_sweeps_reg == '0) ? COUNT_W'(1) : max_sweeps_reg;
  assign last_sweep = (run_count + COUNT_W'(1)) == limit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg       <= SIDE_W'(MAX_SIDE);
      precision_reg  <= PRECISION_RESET;
      max_sweeps_reg <= MAX_SWEEPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SIDE:       side_reg       <= cfg_data[SIDE_W-1:0];
        CFG_PRECISION:  precision_reg  <= cfg_data[PREC_W-1:0];
        CFG_MAX_SWEEPS: max_sweeps_reg <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_RUN:  state_next = T_LAUNCH;
            KIND_READ: state_next = T_READ;
            default:   state_next = T_IDLE;
          endcase
        end
      end
      T_READ:   if (out_free) state_next = T_IDLE;
      T_LAUNCH: state_next = T_SWEEP;
      T_SWEEP: begin
        if (sweep_stat.done) begin
          state_next = (sweep_stat.calm || last_sweep) ? T_REPLY : T_LAUNCH;
        end
      end
      T_REPLY:  if (out_free) state_next = T_IDLE;
      default:  state_next = T_IDLE;
    endcase
  end

  always_comb begin
    item_stall  = !((state == T_IDLE) && out_free);
    start       = (state == T_LAUNCH);
    result_load = (accept && kind != KIND_RUN && kind != KIND_READ) ||
                  ((state == T_READ || state == T_REPLY) && out_free);
    load_read_value = (state == T_READ && read_inside) ? bank_rdata : '0;

    // A sweep writes only the bank that is not the newest.
    bank_we[0] = item_write || (eng_wr_en && newest);
    bank_we[1] = item_write || (eng_wr_en && !newest);
    bank_waddr = (state == T_IDLE) ? item_addr : eng_wr_addr;
    bank_wdata = (state == T_IDLE) ? cell_value : eng_wr_data;
    bank_re    = item_read || eng_rd_en;
    bank_raddr = (state == T_IDLE) ? item_addr : eng_rd_addr;
    bank_rdata = newest ? rdata_b : rdata_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      newest       <= 1'b0;
      sweep_count  <= '0;
      settled      <= 1'b0;
      run_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && kind == KIND_RUN) begin
        run_count <= '0;
      end
      if (state == T_SWEEP && sweep_stat.done) begin
        newest    <= !newest;
        run_count <= run_count + COUNT_W'(1);
        if (sweep_stat.calm || last_sweep) begin
          sweep_count <= run_count + COUNT_W'(1);
          settled     <= sweep_stat.calm;
        end
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_read) begin
      read_inside <= item_inside;
    end
    if (result_load) begin
      read_value  <= load_read_value;
      sweeps_done <= sweep_count;
      converged   <= settled;
    end
  end

  jgr_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_bank_a (
    .clk   (clk),
    .we    (bank_we[0]),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .re    (bank_re),
    .raddr (bank_raddr),
    .rdata (rdata_a)
  );

  jgr_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_bank_b (
    .clk   (clk),
    .we    (bank_we[1]),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .re    (bank_re),
    .raddr (bank_raddr),
    .rdata (rdata_b)
  );

  jgr_sweep #(
    .MAX_SIDE   (MAX_SIDE),
    .VALUE_BITS (VALUE_BITS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .side      (side_used),
    .precision (precision_reg),
    .rd_en     (eng_rd_en),
    .rd_addr   (eng_rd_addr),
    .rd_data   (bank_rdata),
    .wr_en     (eng_wr_en),
    .wr_addr   (eng_wr_addr),
    .wr_data   (eng_wr_data),
    .status    (sweep_stat)
  );

  `JGR_ASSERT(a_done_in_sweep, !sweep_stat.done || state == T_SWEEP,
              "sweep finished outside a run")
  `JGR_ASSERT(a_sweep_dst_bank, !(state != T_IDLE && bank_we[0]) || newest,
              "sweep wrote into the newest bank")
  `JGR_ASSERT(a_count_in_limit, !(state == T_SWEEP) || run_count < limit,
              "sweep count went past the limit")
  `JGR_ASSERT(a_reply_count, !(state == T_REPLY) || sweep_count != '0,
              "run finished with no sweep recorded")
  `JGR_ASSERT_NEXT(a_read_waits, item_read, state == T_READ,
                   "read request did not wait for bank data")

endmodule

FILE: rtl/jgr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/jgr_sweep.sv
// ----------------------------------------------------------------------------
// Jacobi sweep engine
// Walks the interior cells of one sweep through a single read port and one
// shared accumulator, writing each truncated four-neighbor mean.
// ----------------------------------------------------------------------------
module jgr_sweep import jgr_pkg::*; #(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [$clog2(MAX_SIDE+1)-1:0]     side,
  input  logic [PREC_W-1:0]                 precision,
  output logic                              rd_en,
  output logic [2*$clog2(MAX_SIDE)-1:0]     rd_addr,
  input  logic [VALUE_BITS-1:0]             rd_data,
  output logic                              wr_en,
  output logic [2*$clog2(MAX_SIDE)-1:0]     wr_addr,
  output logic [VALUE_BITS-1:0]             wr_data,
  output sweep_stat_t                       status
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ACC_W  = VALUE_BITS + 2;
  localparam int CMP_W  = (VALUE_BITS > PREC_W) ? VALUE_BITS : PREC_W;

  // Per-cell phases: four neighbor reads, the center read, then the write.
  localparam logic [2:0] PH_UP     = 3'd0;
  localparam logic [2:0] PH_DOWN   = 3'd1;
  localparam logic [2:0] PH_LEFT   = 3'd2;
  localparam logic [2:0] PH_RIGHT  = 3'd3;
  localparam logic [2:0] PH_CENTER = 3'd4;
  localparam logic [2:0] PH_WRITE  = 3'd5;

  sweep_state_t     state, state_next;
  logic [IDX_W-1:0] row, col;
  logic [2:0]       phase;
  logic [ACC_W-1:0] acc;
  logic             calm;

  logic [SIDE_W-1:0]     last;
  logic                  col_last, cell_last;
  logic [VALUE_BITS-1:0] mean, diff;
  logic                  over;

  assign last      = side - SIDE_W'(2);
  assign col_last  = SIDE_W'(col) == last;
  assign cell_last = col_last && (SIDE_W'(row) == last);
  assign mean      = acc[ACC_W-1:2];
  // In the write phase the read data holds the old center value.
  assign diff      = (mean > rd_data) ? (mean - rd_data) : (rd_data - mean);
  assign over      = CMP_W'(diff) > CMP_W'(precision);

  always_comb begin
    state_next = state;
    unique case (state)
      SW_IDLE: if (start) state_next = SW_CELL;
      SW_CELL: if (phase == PH_WRITE && cell_last) state_next = SW_IDLE;
      default: state_next = SW_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = (state == SW_CELL) && (phase <= PH_CENTER);
    case (phase)
      PH_UP:    rd_addr = {row - IDX_W'(1), col};
      PH_DOWN:  rd_addr = {row + IDX_W'(1), col};
      PH_LEFT:  rd_addr = {row, col - IDX_W'(1)};
      PH_RIGHT: rd_addr = {row, col + IDX_W'(1)};
      default:  rd_addr = {row, col};
    endcase
    wr_en       = (state == SW_CELL) && (phase == PH_WRITE);
    wr_addr     = {row, col};
    wr_data     = mean;
    status.done = wr_en && cell_last;
    status.calm = calm && !over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      phase <= PH_UP;
    end else begin
      state <= state_next;
      if (state == SW_IDLE) begin
        if (start) begin
          row   <= IDX_W'(1);
          col   <= IDX_W'(1);
          phase <= PH_UP;
          calm  <= 1'b1;
        end
      end else begin
        if (phase == PH_WRITE) begin
          phase <= PH_UP;
          calm  <= calm && !over;
          if (col_last) begin
            col <= IDX_W'(1);
            row <= row + IDX_W'(1);
          end else begin
            col <= col + IDX_W'(1);
          end
        end else begin
          phase <= phase + 3'd1;
        end
        if (phase == PH_DOWN) begin
          acc <= ACC_W'(rd_data);
        end else if (phase >= PH_LEFT && phase <= PH_WRITE && phase != PH_WRITE) begin
          acc <= acc + ACC_W'(rd_data);
        end else if (phase == PH_WRITE) begin
          acc <= acc;
        end
      end
    end
  end

endmodule

FILE: tb/sv/jacobi_grid_relaxation_checker.sv
// ----------------------------------------------------------------------------
// Jacobi grid relaxation checker
// Watches the configuration, request and result ports of the relaxation
// unit, keeps its own copy of the two grid banks, predicts the reply of every
// accepted request and compares each reply field by field in order.
// ----------------------------------------------------------------------------
module jacobi_grid_relaxation_checker import jgr_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic [KIND_W-1:0]                 kind,
  input  logic [$clog2(DEF_MAX_SIDE)-1:0]   row,
  input  logic [$clog2(DEF_MAX_SIDE)-1:0]   column,
  input  logic [DEF_VALUE_BITS-1:0]         cell_value,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic [DEF_VALUE_BITS-1:0]         read_value,
  input  logic [COUNT_W-1:0]                sweeps_done,
  input  logic                              converged,
  output int                                fail_count,
  output int                                pending
);

  localparam int SIDE  = DEF_MAX_SIDE;
  localparam int VBITS = DEF_VALUE_BITS;
  localparam int ADDR_W = $clog2(SIDE);

  typedef struct {
    logic [VBITS-1:0]   value;
    logic [COUNT_W-1:0] sweeps;
    logic               settled;
  } reply_t;

  logic [VBITS-1:0]   cell_bank [0:1][0:SIDE*SIDE-1];
  logic               newest;
  logic [COUNT_W-1:0] last_sweeps;
  logic               last_settled;
  logic [6:0]         side_reg;
  logic [PREC_W-1:0]  precision_reg;
  logic [COUNT_W-1:0] sweep_limit;
  reply_t             replies_due [$];
  int                 errors = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // One Jacobi sweep from the newest bank into the other; true when every
  // interior change stays within the precision.
  function automatic bit sweep_once(int unsigned side);
    int unsigned r, c, at;
    logic [VBITS+1:0] total;
    logic [VBITS-1:0] avg, prior, delta;
    logic src, dst;
    bit calm;
    calm = 1'b1;
    src = newest;
    dst = ~newest;
    for (r = 1; r + 1 < side; r++) begin
      for (c = 1; c + 1 < side; c++) begin
        at = r * SIDE + c;
        total = cell_bank[src][at - SIDE] + cell_bank[src][at + SIDE]
              + cell_bank[src][at + 1] + cell_bank[src][at - 1];
        avg = total[VBITS+1:2];
        prior = cell_bank[src][at];
        delta = (avg > prior) ? avg - prior : prior - avg;
        if (delta > precision_reg) calm = 1'b0;
        cell_bank[dst][at] = avg;
      end
    end
    return calm;
  endfunction

  function automatic void relax_to_rest();
    int unsigned side, limit, count;
    bit calm;
    side = (side_reg < 3) ? 3 : ((side_reg > SIDE) ? SIDE : side_reg);
    limit = (sweep_limit == '0) ? 1 : sweep_limit;
    count = 0;
    calm = 1'b0;
    while (!calm && count < limit) begin
      calm = sweep_once(side);
      newest = ~newest;
      count++;
    end
    last_sweeps = COUNT_W'(count);
    last_settled = calm;
  endfunction

  function automatic reply_t predict_reply(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] r,
                                           logic [ADDR_W-1:0] c, logic [VBITS-1:0] v);
    reply_t rep;
    int unsigned at;
    at = r * SIDE + c;
    rep.value = '0;
    case (k)
      KIND_WRITE: begin
        cell_bank[0][at] = v;
        cell_bank[1][at] = v;
      end
      KIND_RUN: relax_to_rest();
      KIND_READ: rep.value = cell_bank[newest][at];
      default: ;
    endcase
    rep.sweeps = last_sweeps;
    rep.settled = last_settled;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      newest = 1'b0;
      last_sweeps = '0;
      last_settled = 1'b0;
      side_reg = 7'(SIDE);
      precision_reg = PRECISION_RESET;
      sweep_limit = MAX_SWEEPS_RESET;
      replies_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SIDE:       side_reg = cfg_data[6:0];
          CFG_PRECISION:  precision_reg = cfg_data;
          CFG_MAX_SWEEPS: sweep_limit = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected reply: expected none actual %h %h %b",
                   $time, read_value, sweeps_done, converged);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("read_value", 32'(want.value), 32'(read_value));
          check_field("sweeps_done", 32'(want.sweeps), 32'(sweeps_done));
          check_field("converged", 32'(want.settled), 32'(converged));
        end
      end
      if (item_valid && !item_stall)
        replies_due.push_back(predict_reply(kind, row, column, cell_value));
    end
    fail_count <= errors;
    pending <= replies_due.size();
  end

  final begin
    if (replies_due.size() != 0)
      $display("%0t %0d replies still outstanding", $time, replies_due.size());
  end

endmodule

FILE: tb/sv/jacobi_grid_relaxation_unit_tb.sv
// ----------------------------------------------------------------------------
// Jacobi grid relaxation unit testbench
// Drives cell writes, reads, ignored kinds and relaxation runs through several
// register settings and idle patterns, and lets the checker predict every reply.
// ----------------------------------------------------------------------------
module jacobi_grid_relaxation_unit_tb;
  import jgr_pkg::*;

  localparam int SIDE   = DEF_MAX_SIDE;
  localparam int VBITS  = DEF_VALUE_BITS;
  localparam int ADDR_W = $clog2(SIDE);
  localparam logic [KIND_W-1:0] KIND_IGNORED = KIND_W'(3);
  localparam int RANDOM_ITEMS = 1040;
  localparam int PHASES = 8;
  // The longest quiet stretch is a run of 32 sweeps over a seven-wide grid.
  localparam int WATCHDOG_LIMIT = 25000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [KIND_W-1:0]     kind = KIND_WRITE;
  logic [ADDR_W-1:0]     row = '0;
  logic [ADDR_W-1:0]     column = '0;
  logic [VBITS-1:0]      cell_value = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [VBITS-1:0]      read_value;
  logic [COUNT_W-1:0]    sweeps_done;
  logic                  converged;

  int fail_count;
  int pending;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int side_in_use = SIDE;
  int idle_cycles = 0;
  bit cell_filled [0:SIDE*SIDE-1];
  int filled_cells [$];

  jacobi_grid_relaxation_unit uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .kind, .row, .column, .cell_value,
    .result_valid, .result_stall, .read_value, .sweeps_done, .converged
  );

  jacobi_grid_relaxation_checker checker_i (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .kind, .row, .column, .cell_value,
    .result_valid, .result_stall, .read_value, .sweeps_done, .converged,
    .fail_count, .pending
  );

  always #6 clk = ~clk;

  always @(posedge clk) result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] k, input int r, input int c,
                              input int v);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    row <= ADDR_W'(r);
    column <= ADDR_W'(c);
    cell_value <= VBITS'(v);
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Holds the sender back until every reply has come, which leaves the unit idle.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input int side, input int prec, input int sweeps);
    int s;
    s = side & 7'h7F;
    cfg_write <= 1'b1;
    cfg_index <= CFG_SIDE;
    cfg_data <= CFG_DATA_W'(side);
    @(posedge clk);
    cfg_index <= CFG_PRECISION;
    cfg_data <= CFG_DATA_W'(prec);
    @(posedge clk);
    cfg_index <= CFG_MAX_SWEEPS;
    cfg_data <= CFG_DATA_W'(sweeps);
    @(posedge clk);
    cfg_write <= 1'b0;
    side_in_use = (s < 3) ? 3 : ((s > SIDE) ? SIDE : s);
  endtask

  task automatic write_cell(input int r, input int c, input int v);
    send_request(KIND_WRITE, r, c, v);
    if (!cell_filled[r * SIDE + c]) begin
      cell_filled[r * SIDE + c] = 1'b1;
      filled_cells.push_back(r * SIDE + c);
    end
  endtask

  task automatic read_filled_cell();
    int at;
    at = filled_cells[$urandom_range(filled_cells.size() - 1)];
    send_request(KIND_READ, at / SIDE, at % SIDE, $urandom_range(65535));
  endtask

  // A run touches the whole square in use, so any cell there that was never
  // written gets a value first.
  task automatic run_relaxation();
    for (int r = 0; r < side_in_use; r++)
      for (int c = 0; c < side_in_use; c++)
        if (!cell_filled[r * SIDE + c]) write_cell(r, c, $urandom_range(65535));
    send_request(KIND_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
  endtask

  function automatic int random_cell_value();
    case ($urandom_range(7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)
      run_relaxation();
    else if (pick < 10)
      send_request(KIND_IGNORED, $urandom_range(63), $urandom_range(63),
                   $urandom_range(65535));
    else if (pick < 48)
      write_cell($urandom_range(side_in_use - 1), $urandom_range(side_in_use - 1),
                 random_cell_value());
    else if (pick < 55)
      write_cell($urandom_range(63), $urandom_range(63), random_cell_value());
    else
      read_filled_cell();
    if ($urandom_range(199) == 0) drain();
  endtask

  initial begin
    int side_v, prec_v, sweeps_v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corners and extreme values under the reset settings.
    write_cell(0, 0, 0);
    write_cell(63, 63, 65535);
    write_cell(0, 63, 16'h8000);
    write_cell(63, 0, 1);
    write_cell(21, 42, 16'hAAAA);
    write_cell(42, 21, 16'h5555);
    send_request(KIND_READ, 0, 0, 0);
    send_request(KIND_READ, 63, 63, 0);
    send_request(KIND_READ, 0, 63, 0);
    send_request(KIND_READ, 63, 0, 0);
    send_request(KIND_READ, 21, 42, 0);
    send_request(KIND_READ, 42, 21, 65535);
    send_request(KIND_IGNORED, 63, 63, 65535);

    // A side below three folds to three; exact precision settles in two sweeps.
    drain();
    configure(2, 0, 65535);
    run_relaxation();
    send_request(KIND_READ, 1, 1, 0);

    // A zero sweep limit acts as one and the run ends unsettled.
    drain();
    configure(3, 0, 0);
    write_cell(1, 1, 65535);
    run_relaxation();
    send_request(KIND_READ, 1, 1, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 51; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 51; end
        default: begin sender_idle_pct = 7; stall_pct <= 7; end
      endcase
      side_v = $urandom_range(7);
      case ($urandom_range(3))
        0: prec_v = 0;
        1: prec_v = $urandom_range(1, 300);
        2: prec_v = $urandom_range(65535);
        default: prec_v = 65535;
      endcase
      sweeps_v = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 32);
      configure(side_v, prec_v, sweeps_v);
      repeat (RANDOM_ITEMS / PHASES) random_request();
    end

    // A wider square: the widest precision settles in one sweep, then a
    // two-sweep limit stops an exact run early.
    drain();
    sender_idle_pct = 0;
    stall_pct <= 0;
    configure(12, 65535, 0);
    run_relaxation();
    for (int i = 0; i < 6; i++) read_filled_cell();
    drain();
    configure(12, 0, 2);
    run_relaxation();
    for (int i = 0; i < 6; i++) read_filled_cell();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
